// ===== sv/assert_macros.svh =====
// assertion helpers for the shader block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define LBAS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define LBAS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lbas_pkg.sv =====
// ----------------------------------------------------------------------------
// lbas_pkg
// shared constants, types and helper functions of the luma shader block
// ----------------------------------------------------------------------------
package lbas_pkg;

  localparam int MAX_IMAGE_WIDTH  = 2048;
  localparam int MAX_CELLS_ACROSS = 256;
  localparam int MAX_BLOCK_SIDE   = 64;
  localparam int MAX_CELLS_DOWN   = 256;

  localparam int IW_W   = 12;   // image width register
  localparam int BS_W   = 7;    // block side registers
  localparam int CC_W   = 9;    // cell count registers
  localparam int SUM_W  = 20;
  localparam int AREA_W = 13;
  localparam int LIM_W  = 15;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 12;
  localparam int LVL_STEPS = 3;

  localparam logic [CFG_AW-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_BLOCK_WIDTH   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_BLOCK_HEIGHT  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CELLS_ACROSS  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CELLS_DOWN    = 3'd4;
  localparam logic [CFG_AW-1:0] REG_NEGATIVE_MODE = 3'd5;

  localparam logic [23:0] LUM_R = 24'd19595;
  localparam logic [23:0] LUM_G = 24'd38470;
  localparam logic [23:0] LUM_B = 24'd7471;

  typedef struct packed {
    logic div_load;   // start the cells-across division
    logic div_step;
    logic lim_load;   // latch cells across, column limit and block area
    logic accept;
    logic acc;        // accumulate into the cell sum
    logic lvl_step;
    logic emit;
  } lbas_cmd_t;

  typedef struct packed {
    logic blk_end;
    logic out_free;
  } lbas_sts_t;

  function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    logic [23:0] acc;
    acc = LUM_R * {16'd0, r} + LUM_G * {16'd0, g} + LUM_B * {16'd0, b};
    return acc[23:16];
  endfunction

  function automatic logic [6:0] shade(input logic [2:0] lvl);
    logic [6:0] c;
    unique case (lvl)
      3'd0: c = 7'd64;   // @
      3'd1: c = 7'd35;   // #
      3'd2: c = 7'd37;   // %
      3'd3: c = 7'd42;   // *
      3'd4: c = 7'd124;  // |
      3'd5: c = 7'd45;   // -
      3'd6: c = 7'd46;   // .
      3'd7: c = 7'd32;   // space
    endcase
    return c;
  endfunction

endpackage

// ===== sv/lbas_ram.sv =====
// ----------------------------------------------------------------------------
// lbas_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lbas_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lbas_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbas_ctrl
// sequencer: setup division, per-pixel accumulate, level division and emit
// ----------------------------------------------------------------------------
module lbas_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  lbas_pkg::lbas_sts_t sts,
  output lbas_pkg::lbas_cmd_t cmd
);

  localparam logic [2:0] S_START = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_LIMIT = 3'd2;
  localparam logic [2:0] S_IDLE  = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_START: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_SETUP;
      end
      S_SETUP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == 4'(lbas_pkg::IW_W - 1)) begin
          state_nxt = S_LIMIT;
        end
      end
      S_LIMIT: begin
        cmd.lim_load = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        cnt_nxt = '0;
        state_nxt = sts.blk_end ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.lvl_step = 1'b1;
        cnt_nxt      = cnt_r + 4'd1;
        if (cnt_r == 4'(lbas_pkg::LVL_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_START;
      end
    endcase
    // a register write restarts the cells-across division
    if (cfg_wr_en) begin
      state_nxt = S_START;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== sv/lbas_dp.sv =====
// ----------------------------------------------------------------------------
// lbas_dp
// datapath: registers, position counters, cell sums, dividers, output stage
// ----------------------------------------------------------------------------
module lbas_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lbas_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [lbas_pkg::CFG_DW-1:0]       cfg_wdata,
  input  logic [23:0]                       in_tdata,
  input  logic                              in_tuser,
  input  lbas_pkg::lbas_cmd_t               cmd,
  output lbas_pkg::lbas_sts_t               sts,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [7:0]                        out_tdata,
  output logic                              out_tlast,
  output logic                              out_tuser
);

  // configuration
  logic [lbas_pkg::IW_W-1:0] img_w_r;
  logic [lbas_pkg::BS_W-1:0] blk_w_r, blk_h_r;
  logic [lbas_pkg::CC_W-1:0] cells_a_r, cells_d_r;
  logic                      neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= 12'd640;
      blk_w_r   <= 7'd8;
      blk_h_r   <= 7'd8;
      cells_a_r <= 9'd80;
      cells_d_r <= 9'd60;
      neg_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        lbas_pkg::REG_IMAGE_WIDTH:   img_w_r   <= cfg_wdata;
        lbas_pkg::REG_BLOCK_WIDTH:   blk_w_r   <= cfg_wdata[6:0];
        lbas_pkg::REG_BLOCK_HEIGHT:  blk_h_r   <= cfg_wdata[6:0];
        lbas_pkg::REG_CELLS_ACROSS:  cells_a_r <= cfg_wdata[8:0];
        lbas_pkg::REG_CELLS_DOWN:    cells_d_r <= cfg_wdata[8:0];
        lbas_pkg::REG_NEGATIVE_MODE: neg_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the bound as the bound
  logic [lbas_pkg::IW_W-1:0] w_c;
  logic [lbas_pkg::BS_W-1:0] bw_c, bh_c;
  logic [lbas_pkg::CC_W-1:0] ca_c, cd_c;

  always_comb begin
    w_c  = (img_w_r == '0) ? 12'd1 :
           (img_w_r > 12'(lbas_pkg::MAX_IMAGE_WIDTH)) ? 12'(lbas_pkg::MAX_IMAGE_WIDTH)
                                                      : img_w_r;
    bw_c = (blk_w_r == '0) ? 7'd1 :
           (blk_w_r > 7'(lbas_pkg::MAX_BLOCK_SIDE)) ? 7'(lbas_pkg::MAX_BLOCK_SIDE) : blk_w_r;
    bh_c = (blk_h_r == '0) ? 7'd1 :
           (blk_h_r > 7'(lbas_pkg::MAX_BLOCK_SIDE)) ? 7'(lbas_pkg::MAX_BLOCK_SIDE) : blk_h_r;
    ca_c = (cells_a_r == '0) ? 9'd1 :
           (cells_a_r > 9'(lbas_pkg::MAX_CELLS_ACROSS)) ? 9'(lbas_pkg::MAX_CELLS_ACROSS)
                                                        : cells_a_r;
    cd_c = (cells_d_r == '0) ? 9'd1 :
           (cells_d_r > 9'(lbas_pkg::MAX_CELLS_DOWN)) ? 9'(lbas_pkg::MAX_CELLS_DOWN)
                                                      : cells_d_r;
  end

  // image width / block width, one quotient bit a cycle
  logic [6:0]                 drem_r;
  logic [lbas_pkg::IW_W-1:0]  dquo_r;
  logic [7:0]                 dtry;
  logic                       dbit;
  logic [lbas_pkg::CC_W-1:0]  across_r;
  logic [lbas_pkg::LIM_W-1:0] limit_r;
  logic [lbas_pkg::AREA_W-1:0] area_r;
  logic [lbas_pkg::CC_W-1:0]  across_c;

  assign dtry = {drem_r, dquo_r[lbas_pkg::IW_W-1]};
  assign dbit = dtry >= {1'b0, bw_c};
  assign across_c = (dquo_r > {3'b0, ca_c}) ? ca_c : dquo_r[lbas_pkg::CC_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      drem_r <= '0;
      dquo_r <= w_c;
    end else if (cmd.div_step) begin
      drem_r <= dbit ? 7'(dtry - {1'b0, bw_c}) : dtry[6:0];
      dquo_r <= {dquo_r[lbas_pkg::IW_W-2:0], dbit};
    end
    if (cmd.lim_load) begin
      across_r <= across_c;
      limit_r  <= 15'(across_c * bw_c);
      area_r   <= 13'(bw_c * bh_c);
    end
  end

  // position counters
  logic [10:0] pix_col_r;
  logic [5:0]  row_ib_r, col_ib_r;
  logic [7:0]  cell_col_r;
  logic [8:0]  cell_row_r;
  logic [7:0]  lum_r;
  logic [255:0] vld_r;

  logic [7:0]  raddr;
  logic [lbas_pkg::SUM_W-1:0] rdata, sum_old, sum_new;
  logic        in_range, blk_end;
  logic [6:0]  row_nx, col_nx;
  logic        row_wrap;

  assign raddr    = in_tuser ? 8'd0 : cell_col_r;
  assign sum_old  = vld_r[cell_col_r] ? rdata : '0;
  assign sum_new  = sum_old + {12'd0, lum_r};
  assign in_range = (cell_row_r < cd_c) && ({4'd0, pix_col_r} < limit_r);
  assign blk_end  = in_range && ({1'b0, row_ib_r} == bh_c - 7'd1)
                    && ({1'b0, col_ib_r} == bw_c - 7'd1);
  assign row_nx   = {1'b0, row_ib_r} + 7'd1;
  assign col_nx   = {1'b0, col_ib_r} + 7'd1;
  assign row_wrap = ({1'b0, pix_col_r} + 12'd1) >= w_c;

  lbas_ram #(.WIDTH(lbas_pkg::SUM_W), .DEPTH(lbas_pkg::MAX_CELLS_ACROSS)) u_sums (
    .clk   (clk),
    .we    (cmd.acc && in_range),
    .waddr (cell_col_r),
    .wdata (blk_end ? '0 : sum_new),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_col_r  <= '0;
      row_ib_r   <= '0;
      col_ib_r   <= '0;
      cell_col_r <= '0;
      cell_row_r <= '0;
      vld_r      <= '0;
    end else if (cmd.accept) begin
      if (in_tuser) begin
        pix_col_r  <= '0;
        row_ib_r   <= '0;
        col_ib_r   <= '0;
        cell_col_r <= '0;
        cell_row_r <= '0;
        vld_r      <= '0;
      end
    end else if (cmd.acc) begin
      if (in_range) begin
        vld_r[cell_col_r] <= 1'b1;
      end
      if (row_wrap) begin
        pix_col_r  <= '0;
        col_ib_r   <= '0;
        cell_col_r <= '0;
        if (row_nx >= bh_c) begin
          row_ib_r <= '0;
          if (cell_row_r < cd_c) begin
            cell_row_r <= cell_row_r + 9'd1;
          end
        end else begin
          row_ib_r <= row_nx[5:0];
        end
      end else begin
        pix_col_r <= pix_col_r + 11'd1;
        if (col_nx >= bw_c) begin
          col_ib_r <= '0;
          if (cell_col_r != 8'd255) begin
            cell_col_r <= cell_col_r + 8'd1;
          end
        end else begin
          col_ib_r <= col_nx[5:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      lum_r <= lbas_pkg::luma(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
    end
  end

  // level = sum / (32 * area), saturated at seven
  logic [lbas_pkg::SUM_W-1:0] lrem_r, lden_r;
  logic [2:0] lq_r;
  logic       lsat_r, lastc_r, eof_r, lbit;
  logic       lastc;
  logic [2:0] lvl;

  assign lastc = ({1'b0, cell_col_r} == across_r - 9'd1);
  assign lbit  = lrem_r >= lden_r;

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      lrem_r  <= sum_new;
      lden_r  <= 20'({area_r, 7'd0});
      lq_r    <= '0;
      lsat_r  <= {2'b0, sum_new} >= 22'({area_r, 8'd0});
      lastc_r <= lastc;
      eof_r   <= lastc && (cell_row_r == cd_c - 9'd1);
    end else if (cmd.lvl_step) begin
      if (lbit) begin
        lrem_r <= lrem_r - lden_r;
      end
      lq_r   <= {lq_r[1:0], lbit};
      lden_r <= lden_r >> 1;
    end
  end

  assign lvl = (lsat_r ? 3'd7 : lq_r) ^ {3{neg_r}};

  // output stage
  logic       ovld_r;
  logic [6:0] ochar_r;
  logic       olast_r, oeof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (cmd.emit) begin
      ovld_r <= 1'b1;
    end else if (out_tready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ochar_r <= lbas_pkg::shade(lvl);
      olast_r <= lastc_r;
      oeof_r  <= eof_r;
    end
  end

  assign sts.blk_end  = blk_end;
  assign sts.out_free = !ovld_r || out_tready;
  assign out_tvalid   = ovld_r;
  assign out_tdata    = {1'b0, ochar_r};
  assign out_tlast    = olast_r;
  assign out_tuser    = oeof_r;

endmodule

// ===== sv/luma_block_average_ascii_shader_unit.sv =====
// a block's last pixel goes through the accumulate state, the 3-step level divider and the
// emit state, which waits for a free output register; a pixel is taken only while idle,
// so none is taken before the last is through; after reset or any register write the
// cells-across divider runs, during which no pixel is taken; rst_n is synchronous, active low
// reset loads the default registers and clears counters and cell-sum valid bits
// ----------------------------------------------------------------------------
// luma_block_average_ascii_shader_unit
// block-averaged luminance to ascii shade converter, top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module luma_block_average_ascii_shader_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [lbas_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [lbas_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [23:0]                  in_tdata,   // red, green, blue
  input  logic                         in_tuser,   // frame_start
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata,  // shade_char, zero pad
  output logic                         out_tlast,  // end_of_row
  output logic                         out_tuser   // end_of_frame
);

  lbas_pkg::lbas_cmd_t cmd;
  lbas_pkg::lbas_sts_t sts;

  lbas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lbas_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `LBAS_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "pixel taken back to back")
  `LBAS_ASSERT(a_cfg_stalls, cfg_wr_en |=> !in_tready, "pixel taken during setup")
  `LBAS_ASSERT(a_eof_on_row_end, out_tvalid && out_tuser |-> out_tlast, "frame end off row end")

endmodule

// ===== dv/lbas_shade_checker.sv =====
// ----------------------------------------------------------------------------
// lbas_shade_checker
// watches the pixel and shade channels, predicts each shade beat from the
// accepted pixels and the register writes, and compares field by field
// ----------------------------------------------------------------------------
module lbas_shade_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [lbas_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [lbas_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [23:0]                  in_tdata,
  input  logic                         in_tuser,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [7:0]                   out_tdata,
  input  logic                         out_tlast,
  input  logic                         out_tuser,
  output int                           fail_count,
  output int                           pending,
  output int                           shades_seen,
  output int                           frames_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [6:0] ch;
    logic       row_end;
    logic       frame_end;
  } shade_beat_t;

  shade_beat_t shade_q[$];

  logic [11:0] img_w_r;
  logic [6:0]  blk_w_r, blk_h_r;
  logic [8:0]  across_r, down_r;
  logic        neg_r;
  int unsigned sums[256];
  int unsigned px_col, row_blk, col_blk, cell_col, cell_row;

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [6:0] shade_of(int unsigned lvl);
    logic [6:0] tbl[8];
    tbl = '{7'd64, 7'd35, 7'd37, 7'd42, 7'd124, 7'd45, 7'd46, 7'd32};
    return tbl[lvl];
  endfunction

  task automatic predict_pixel(input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic fs);
    int unsigned w, bw, bh, ca, cd, across, lum, s, lvl;
    shade_beat_t e;
    w  = clamp(img_w_r, lbas_pkg::MAX_IMAGE_WIDTH);
    bw = clamp(blk_w_r, lbas_pkg::MAX_BLOCK_SIDE);
    bh = clamp(blk_h_r, lbas_pkg::MAX_BLOCK_SIDE);
    ca = clamp(across_r, lbas_pkg::MAX_CELLS_ACROSS);
    cd = clamp(down_r, lbas_pkg::MAX_CELLS_DOWN);
    across = w / bw;
    if (across > ca) across = ca;
    if (fs) begin
      foreach (sums[i]) sums[i] = 0;
      px_col = 0; row_blk = 0; col_blk = 0; cell_col = 0; cell_row = 0;
    end
    lum = (19595 * r + 38470 * g + 7471 * b) >> 16;
    if (cell_row < cd && px_col < across * bw && cell_col < 256) begin
      s = (sums[cell_col] + lum) & 20'hFFFFF;
      sums[cell_col] = s;
      if (row_blk == bh - 1 && col_blk == bw - 1) begin
        lvl = (s / (bw * bh)) >> 5;
        if (lvl > 7) lvl = 7;
        if (neg_r) lvl = 7 - lvl;
        e.ch = shade_of(lvl);
        e.row_end = (cell_col == across - 1);
        e.frame_end = e.row_end && (cell_row == cd - 1);
        shade_q.push_back(e);
        sums[cell_col] = 0;
      end
    end
    if (px_col + 1 >= w) begin
      px_col = 0; col_blk = 0; cell_col = 0;
      row_blk++;
      if (row_blk >= bh) begin
        row_blk = 0;
        if (cell_row < cd) cell_row++;
      end
    end else begin
      px_col++;
      col_blk++;
      if (col_blk >= bw) begin
        col_blk = 0;
        if (cell_col < 255) cell_col++;
      end
    end
  endtask

  assign pending = shade_q.size();

  always @(posedge clk) begin
    shade_beat_t e;
    if (!rst_n) begin
      img_w_r <= 12'd640; blk_w_r <= 7'd8; blk_h_r <= 7'd8;
      across_r <= 9'd80; down_r <= 9'd60; neg_r <= 1'b0;
      foreach (sums[i]) sums[i] = 0;
      px_col = 0; row_blk = 0; col_blk = 0; cell_col = 0; cell_row = 0;
      shade_q.delete();
      fail_count = 0;
      shades_seen = 0;
      frames_seen = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          lbas_pkg::REG_IMAGE_WIDTH:   img_w_r  <= cfg_wdata[11:0];
          lbas_pkg::REG_BLOCK_WIDTH:   blk_w_r  <= cfg_wdata[6:0];
          lbas_pkg::REG_BLOCK_HEIGHT:  blk_h_r  <= cfg_wdata[6:0];
          lbas_pkg::REG_CELLS_ACROSS:  across_r <= cfg_wdata[8:0];
          lbas_pkg::REG_CELLS_DOWN:    down_r   <= cfg_wdata[8:0];
          lbas_pkg::REG_NEGATIVE_MODE: neg_r    <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_pixel(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16], in_tuser);
      if (out_tvalid && out_tready) begin
        shades_seen++;
        if (out_tuser) frames_seen++;
        if (shade_q.size() == 0) begin
          $error("shade beat with nothing expected: char %0d", out_tdata);
          fail_count++;
        end else begin
          e = shade_q.pop_front();
          if (out_tdata != {1'b0, e.ch}) begin
            $error("shade_char: expected %0d, got %0d", e.ch, out_tdata);
            fail_count++;
          end
          if (out_tlast != e.row_end) begin
            $error("end_of_row: expected %0b, got %0b", e.row_end, out_tlast);
            fail_count++;
          end
          if (out_tuser != e.frame_end) begin
            $error("end_of_frame: expected %0b, got %0b", e.frame_end, out_tuser);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== dv/luma_block_average_ascii_shader_unit_test.sv =====
// ----------------------------------------------------------------------------
// luma_block_average_ascii_shader_unit_test
// drives pixel frames under several block geometries and shade modes, with
// random stalls on both channels; the checker predicts and compares shades
// ----------------------------------------------------------------------------
module luma_block_average_ascii_shader_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_wr_en = 1'b0;
  logic [lbas_pkg::CFG_AW-1:0]   cfg_addr = '0;
  logic [lbas_pkg::CFG_DW-1:0]   cfg_wdata = '0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [23:0]                   in_tdata = '0;
  logic                          in_tuser = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [7:0]                    out_tdata;
  logic                          out_tlast;
  logic                          out_tuser;
  int                            fail_count, pending, shades_seen, frames_seen;
  int                            pixels_sent = 0;
  bit                            calm = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  luma_block_average_ascii_shader_unit u_dut (.*);

  lbas_shade_checker u_chk (.*);

  // sink stalls in bursts
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [lbas_pkg::CFG_AW-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[lbas_pkg::CFG_DW-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned iw, input int unsigned bw,
                              input int unsigned bh, input int unsigned ca,
                              input int unsigned cd, input bit neg);
    drain();
    write_reg(lbas_pkg::REG_IMAGE_WIDTH, iw);
    write_reg(lbas_pkg::REG_BLOCK_WIDTH, bw);
    write_reg(lbas_pkg::REG_BLOCK_HEIGHT, bh);
    write_reg(lbas_pkg::REG_CELLS_ACROSS, ca);
    write_reg(lbas_pkg::REG_CELLS_DOWN, cd);
    write_reg(lbas_pkg::REG_NEGATIVE_MODE, neg);
  endtask

  task automatic send_pixel(input logic [23:0] rgb, input logic fs);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rgb;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic idle_input;
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
  endtask

  // one frame of n pixels; flat level picks a band, otherwise random pixels
  task automatic send_frame(input int n, input int mode);
    logic [23:0] px;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: px = 24'($urandom);
        1: px = 24'h000000;
        2: px = 24'hFFFFFF;
        default: begin
          px[7:0] = 8'($urandom_range(0, 255));
          px[23:8] = {px[7:0], px[7:0]};
        end
      endcase
      send_pixel(px, i == 0 || ($urandom_range(0, 400) == 0));
    end
    idle_input();
  endtask

  initial begin
    int iw, bw, bh, ca, cd;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (20) @(posedge clk);

    // directed: extremes of colour and each level band
    set_geometry(4, 2, 2, 2, 2, 0);
    send_frame(16, 1);
    send_frame(16, 2);
    set_geometry(4, 1, 1, 4, 2, 1);
    for (int l = 0; l < 8; l++) send_pixel({3{8'(l * 32 + 16)}}, l == 0);
    send_pixel(24'h0000FF, 1'b1);
    send_pixel(24'h00FF00, 1'b0);
    send_pixel(24'hFF0000, 1'b0);
    idle_input();
    // width not a multiple of block, cells clamp, pixels past last row
    set_geometry(7, 3, 1, 1, 1, 0);
    send_frame(10, 0);
    // zero registers act as 1
    set_geometry(0, 0, 0, 0, 0, 0);
    send_frame(3, 0);
    // no whole block across: nothing out
    set_geometry(2, 3, 1, 4, 2, 0);
    send_frame(4, 0);
    drain();

    // random frames with small geometry
    while (pixels_sent < 780) begin
      bw = $urandom_range(1, 4);
      bh = $urandom_range(1, 4);
      iw = $urandom_range(1, 12);
      ca = $urandom_range(1, 5);
      cd = $urandom_range(1, 4);
      set_geometry(iw, bw, bh, ca, cd, $urandom_range(0, 1));
      repeat ($urandom_range(1, 3)) send_frame(iw * bh * cd + int'($urandom_range(0, 3)),
                                              int'($urandom_range(0, 4)));
    end

    // maximum register values and overflow values, short frames
    set_geometry(4095, 127, 127, 511, 511, 1);
    send_frame(40, 0);
    set_geometry(2048, 64, 1, 256, 256, 0);
    send_frame(128, 0);
    set_geometry(64, 64, 1, 1, 1, 1);
    send_frame(64, 2);

    // quiet tail
    set_geometry(8, 2, 2, 4, 2, 0);
    calm = 1'b1;
    send_frame(32, 0);
    drain();
    repeat (30) @(posedge clk);

    $display("covered %0d pixels, %0d shade beats, %0d frame ends", pixels_sent,
             shades_seen, frames_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule

// ===== luma_block_average_ascii_shader_unit.f =====
+incdir+sv
sv/lbas_pkg.sv
sv/lbas_ram.sv
sv/lbas_ctrl.sv
sv/lbas_dp.sv
sv/luma_block_average_ascii_shader_unit.sv
dv/lbas_shade_checker.sv
dv/luma_block_average_ascii_shader_unit_test.sv
